/* rtl/core/evg_pkg.sv */
// Shared types, constants and the CORDIC arctangent table of the ellipse vertex generator.
package evg_pkg;

  localparam int IDX_W        = 12;
  localparam int COORD_W      = 32;
  localparam int TRIG_W       = 34;
  localparam int CORDIC_STEPS = 30;
  localparam int MIN_VERTICES = 3;
  localparam logic signed [TRIG_W-1:0] CORDIC_X0 = 34'sd652032874;

  typedef enum logic [2:0] {
    REG_CENTER_X     = 3'd0,
    REG_CENTER_Y     = 3'd1,
    REG_RADIUS_X     = 3'd2,
    REG_RADIUS_Y     = 3'd3,
    REG_VERTEX_COUNT = 3'd4
  } reg_index_t;

  typedef struct packed {
    logic first;
    logic last;
    logic shape_ok;
    logic err;
  } tag_t;

  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] a;
    case (i)
      5'd0:  a = 32'd536870912;
      5'd1:  a = 32'd316933406;
      5'd2:  a = 32'd167458907;
      5'd3:  a = 32'd85004756;
      5'd4:  a = 32'd42667331;
      5'd5:  a = 32'd21354465;
      5'd6:  a = 32'd10679838;
      5'd7:  a = 32'd5340245;
      5'd8:  a = 32'd2670163;
      5'd9:  a = 32'd1335087;
      5'd10: a = 32'd667544;
      5'd11: a = 32'd333772;
      5'd12: a = 32'd166886;
      5'd13: a = 32'd83443;
      5'd14: a = 32'd41722;
      5'd15: a = 32'd20861;
      5'd16: a = 32'd10430;
      5'd17: a = 32'd5215;
      5'd18: a = 32'd2608;
      5'd19: a = 32'd1304;
      5'd20: a = 32'd652;
      5'd21: a = 32'd326;
      5'd22: a = 32'd163;
      5'd23: a = 32'd81;
      5'd24: a = 32'd41;
      5'd25: a = 32'd20;
      5'd26: a = 32'd10;
      5'd27: a = 32'd5;
      5'd28: a = 32'd3;
      5'd29: a = 32'd1;
      default: a = 32'd0;
    endcase
    return a;
  endfunction

endpackage

/* rtl/core/evg_div.sv */
// Pipelined restoring divider: phase = floor(index * 2^ANGLE_BITS / count), one bit per stage.
module evg_div import evg_pkg::*; #(
  parameter int ANGLE_BITS = 24
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  advance,
  input  logic                  in_vld,
  input  tag_t                  in_tag,
  input  logic [IDX_W-1:0]      index,
  input  logic [IDX_W-1:0]      count,
  output logic                  out_vld,
  output tag_t                  out_tag,
  output logic [ANGLE_BITS-1:0] phase
);

  logic [IDX_W-1:0]      rem [1:ANGLE_BITS];
  logic [ANGLE_BITS-1:0] quo [1:ANGLE_BITS];
  logic                  vld [1:ANGLE_BITS];
  tag_t                  tag [1:ANGLE_BITS];

  for (genvar k = 0; k < ANGLE_BITS; k++) begin : g_stage
    logic [IDX_W-1:0]      rem_prev;
    logic [ANGLE_BITS-1:0] quo_prev;
    logic                  vld_prev;
    tag_t                  tag_prev;
    logic [IDX_W:0]        shifted;
    logic                  ge;

    if (k == 0) begin : g_first
      assign rem_prev = in_tag.err ? '0 : index;
      assign quo_prev = '0;
      assign vld_prev = in_vld;
      assign tag_prev = in_tag;
    end else begin : g_rest
      assign rem_prev = rem[k];
      assign quo_prev = quo[k];
      assign vld_prev = vld[k];
      assign tag_prev = tag[k];
    end

    assign shifted = {rem_prev, 1'b0};
    assign ge      = shifted >= {1'b0, count};

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k+1] <= 1'b0;
      end else if (advance) begin
        vld[k+1] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        rem[k+1] <= ge ? IDX_W'(shifted - {1'b0, count}) : shifted[IDX_W-1:0];
        quo[k+1] <= {quo_prev[ANGLE_BITS-1:0] << 1} | ANGLE_BITS'(ge);
        tag[k+1] <= tag_prev;
      end
    end
  end

  assign out_vld = vld[ANGLE_BITS];
  assign out_tag = tag[ANGLE_BITS];
  assign phase   = quo[ANGLE_BITS];

endmodule

/* rtl/core/evg_cordic.sv */
// Pipelined rotation-mode CORDIC: one iteration per stage, quadrant fold and negate at the ends.
module evg_cordic import evg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     advance,
  input  logic                     in_vld,
  input  tag_t                     in_tag,
  input  logic [31:0]              turn,
  output logic                     out_vld,
  output tag_t                     out_tag,
  output logic signed [TRIG_W-1:0] cos_q,
  output logic signed [TRIG_W-1:0] sin_q
);

  logic signed [TRIG_W-1:0] xs [1:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] ys [1:CORDIC_STEPS];
  logic signed [TRIG_W-1:0] zs [1:CORDIC_STEPS];
  logic                     fl [1:CORDIC_STEPS];
  logic                     vld [1:CORDIC_STEPS];
  tag_t                     tag [1:CORDIC_STEPS];

  logic        flip_in;
  logic [31:0] turn_fold;

  assign flip_in   = turn[31] ^ turn[30];
  assign turn_fold = flip_in ? {~turn[31], turn[30:0]} : turn;

  for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_iter
    logic signed [TRIG_W-1:0] x_prev, y_prev, z_prev, dx, dy, at;
    logic                     fl_prev, vld_prev;
    tag_t                     tag_prev;

    if (i == 0) begin : g_first
      assign x_prev   = CORDIC_X0;
      assign y_prev   = '0;
      assign z_prev   = TRIG_W'($signed(turn_fold));
      assign fl_prev  = flip_in;
      assign vld_prev = in_vld;
      assign tag_prev = in_tag;
    end else begin : g_rest
      assign x_prev   = xs[i];
      assign y_prev   = ys[i];
      assign z_prev   = zs[i];
      assign fl_prev  = fl[i];
      assign vld_prev = vld[i];
      assign tag_prev = tag[i];
    end

    assign dx = y_prev >>> i;
    assign dy = x_prev >>> i;
    assign at = $signed({2'b00, atan_turn(5'(i))});

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[i+1] <= 1'b0;
      end else if (advance) begin
        vld[i+1] <= vld_prev;
      end
    end

    always_ff @(posedge clk) begin
      if (advance) begin
        if (!z_prev[TRIG_W-1]) begin
          xs[i+1] <= x_prev - dx;
          ys[i+1] <= y_prev + dy;
          zs[i+1] <= z_prev - at;
        end else begin
          xs[i+1] <= x_prev + dx;
          ys[i+1] <= y_prev - dy;
          zs[i+1] <= z_prev + at;
        end
        fl[i+1]  <= fl_prev;
        tag[i+1] <= tag_prev;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (advance) begin
      out_vld <= vld[CORDIC_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      cos_q   <= fl[CORDIC_STEPS] ? -xs[CORDIC_STEPS] : xs[CORDIC_STEPS];
      sin_q   <= fl[CORDIC_STEPS] ? -ys[CORDIC_STEPS] : ys[CORDIC_STEPS];
      out_tag <= tag[CORDIC_STEPS];
    end
  end

endmodule

/* rtl/core/evg_place.sv */
// Scale by radius, round to Q16.16, add center and saturate (or clear to zero); two register stages.
module evg_place import evg_pkg::*; (
  input  logic                      clk,
  input  logic                      advance,
  input  logic signed [COORD_W-1:0] center,
  input  logic signed [COORD_W-1:0] radius,
  input  logic signed [TRIG_W-1:0]  trig,
  input  logic                      clear,
  output logic signed [COORD_W-1:0] point
);

  localparam int PROD_W = COORD_W + TRIG_W;
  localparam int RND_W  = PROD_W - 30;
  localparam int SUM_W  = RND_W + 1;

  logic signed [PROD_W-1:0] prod;
  logic signed [RND_W-1:0]  rounded;
  logic signed [SUM_W-1:0]  sum;
  logic signed [SUM_W-1:0]  sat_hi, sat_lo;

  assign rounded = RND_W'((prod + PROD_W'(64'sd536870912)) >>> 30);
  assign sum     = SUM_W'(rounded) + SUM_W'(center);
  assign sat_hi  = SUM_W'(64'sd2147483647);
  assign sat_lo  = SUM_W'(-64'sd2147483648);

  always_ff @(posedge clk) begin
    if (advance) begin
      prod <= PROD_W'(radius) * PROD_W'(trig);
      if (clear) begin
        point <= '0;
      end else if (sum > sat_hi) begin
        point <= COORD_W'(sat_hi);
      end else if (sum < sat_lo) begin
        point <= COORD_W'(sat_lo);
      end else begin
        point <= COORD_W'(sum);
      end
    end
  end

endmodule

/* rtl/core/ellipse_vertex_generator.sv */
// Top level of the ellipse vertex generator: config registers, pipeline and flow control.
//
//  channel | signals                                   | transfer when
//  in      | in_valid, in_stall, vertex_index          | in_valid && !in_stall
//  out     | out_valid, out_stall, point_x .. index_error | out_valid && !out_stall
//  cfg     | cfg_write, cfg_index, cfg_data            | cfg_write
//
// One vertex per cycle while out_stall does not hold a valid output; the pipeline holds the divider
// bits, 30 CORDIC iterations plus fold, multiply, round and saturate.
// Reset clears all stage valid bits and the center and radius registers, and sets the vertex count to MIN_VERTICES.
// A stall on a valid output freezes the whole pipeline; in_stall follows it.
module ellipse_vertex_generator import evg_pkg::*; #(
  parameter int MAX_VERTICES = 4096,
  parameter int ANGLE_BITS   = 24
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      cfg_write,
  input  logic [2:0]                cfg_index,
  input  logic [COORD_W-1:0]        cfg_data,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic [IDX_W-1:0]          vertex_index,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [COORD_W-1:0] point_x,
  output logic signed [COORD_W-1:0] point_y,
  output logic                      is_first,
  output logic                      is_last,
  output logic                      shape_valid,
  output logic                      index_error
);

  logic signed [COORD_W-1:0] center_x, center_y, radius_x, radius_y;
  logic [IDX_W-1:0]          vertex_count;
  logic [IDX_W-1:0]          count;
  logic                      advance;
  tag_t                      in_tag, div_tag, cor_tag, mul_tag, out_tag;
  logic                      div_vld, cor_vld, mul_vld;
  logic [ANGLE_BITS-1:0]     phase;
  logic signed [TRIG_W-1:0]  cos_q, sin_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      center_x     <= '0;
      center_y     <= '0;
      radius_x     <= '0;
      radius_y     <= '0;
      vertex_count <= IDX_W'(MIN_VERTICES);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_CENTER_X:     center_x     <= cfg_data;
        REG_CENTER_Y:     center_y     <= cfg_data;
        REG_RADIUS_X:     radius_x     <= cfg_data;
        REG_RADIUS_Y:     radius_y     <= cfg_data;
        REG_VERTEX_COUNT: vertex_count <= cfg_data[IDX_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (vertex_count < IDX_W'(MIN_VERTICES)) begin
      count = IDX_W'(MIN_VERTICES);
    end else if (32'(vertex_count) > 32'(MAX_VERTICES)) begin
      count = IDX_W'(MAX_VERTICES);
    end else begin
      count = vertex_count;
    end
  end

  assign advance  = !out_valid || !out_stall;
  assign in_stall = !advance;

  assign in_tag.err      = vertex_index >= count;
  assign in_tag.first    = vertex_index == '0;
  assign in_tag.last     = vertex_index == count - IDX_W'(1);
  assign in_tag.shape_ok = (radius_x > 0) && (radius_y > 0);

  evg_div #(.ANGLE_BITS(ANGLE_BITS)) u_div (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_vld  (in_valid),
    .in_tag  (in_tag),
    .index   (vertex_index),
    .count   (count),
    .out_vld (div_vld),
    .out_tag (div_tag),
    .phase   (phase)
  );

  evg_cordic u_cordic (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .in_vld  (div_vld),
    .in_tag  (div_tag),
    .turn    (32'(phase) << (32 - ANGLE_BITS)),
    .out_vld (cor_vld),
    .out_tag (cor_tag),
    .cos_q   (cos_q),
    .sin_q   (sin_q)
  );

  evg_place u_place_x (
    .clk     (clk),
    .advance (advance),
    .center  (center_x),
    .radius  (radius_x),
    .trig    (cos_q),
    .clear   (mul_tag.err),
    .point   (point_x)
  );

  evg_place u_place_y (
    .clk     (clk),
    .advance (advance),
    .center  (center_y),
    .radius  (radius_y),
    .trig    (sin_q),
    .clear   (mul_tag.err),
    .point   (point_y)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_vld   <= 1'b0;
      out_valid <= 1'b0;
    end else if (advance) begin
      mul_vld   <= cor_vld;
      out_valid <= mul_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      mul_tag <= cor_tag;
      out_tag <= mul_tag;
    end
  end

  assign is_first    = out_tag.first && !out_tag.err;
  assign is_last     = out_tag.last && !out_tag.err;
  assign shape_valid = out_tag.shape_ok;
  assign index_error = out_tag.err;

endmodule

/* rtl/core/evg_checker.sv */
// Port-level checks of the ellipse vertex generator, bound to the top level.
module evg_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [31:0] point_x,
  input logic [31:0] point_y,
  input logic        is_first,
  input logic        is_last,
  input logic        index_error
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(point_x) && $stable(point_y))
    else $error("result changed while stalled");

  a_back: assert property (@(posedge clk) disable iff (rst)
    in_stall == (out_valid && out_stall))
    else $error("input stall does not follow output stall");

  a_err: assert property (@(posedge clk) disable iff (rst)
    out_valid && index_error |-> point_x == 32'd0 && point_y == 32'd0 && !is_first && !is_last)
    else $error("index error with nonzero result");

  a_empty: assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result right after reset");

endmodule

bind ellipse_vertex_generator evg_checker u_evg_checker (
  .clk         (clk),
  .rst         (rst),
  .in_stall    (in_stall),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .point_x     (point_x),
  .point_y     (point_y),
  .is_first    (is_first),
  .is_last     (is_last),
  .index_error (index_error)
);
